### rtl/bu2x_pkg.sv
// shared types and constants of the 2x bilinear upscaler
`timescale 1ns / 1ps

package bu2x_pkg;

    localparam int MAX_WIDTH  = 1024;
    localparam int MAX_HEIGHT = 1024;
    localparam int CH_BITS    = 16;

    localparam int COL_BITS   = $clog2(MAX_WIDTH);
    localparam int ROW_BITS   = $clog2(MAX_HEIGHT);
    localparam int CFG_BITS   = 11;
    localparam int COORD_BITS = 11;

    localparam int APB_DW     = 32;
    localparam int ADDR_BITS  = 3;

    localparam logic [CFG_BITS-1:0] WIDTH_RST  = CFG_BITS'(640);
    localparam logic [CFG_BITS-1:0] HEIGHT_RST = CFG_BITS'(480);
    localparam logic [CFG_BITS-1:0] WIDTH_MAX  = CFG_BITS'(MAX_WIDTH);
    localparam logic [CFG_BITS-1:0] HEIGHT_MAX = CFG_BITS'(MAX_HEIGHT);

    typedef struct packed {
        logic [CH_BITS-1:0] red;
        logic [CH_BITS-1:0] green;
        logic [CH_BITS-1:0] blue;
    } t_pix;

    // which of the up to four results of one source pixel
    typedef enum logic [1:0] {
        K_COPY,
        K_HMID,
        K_VMID,
        K_QUAD
    } t_kind;

    typedef enum logic {
        REG_SRC_WIDTH,
        REG_SRC_HEIGHT
    } t_reg;

endpackage

### rtl/bu2x_if.sv
// valid/ready channel interfaces for source pixels and upscaled pixels
`timescale 1ns / 1ps

interface bu2x_pix_if;
    import bu2x_pkg::*;

    logic               valid;
    logic               ready;
    logic [CH_BITS-1:0] red;
    logic [CH_BITS-1:0] green;
    logic [CH_BITS-1:0] blue;

    modport source (output valid, output red, output green, output blue, input ready);
    modport sink (input valid, input red, input green, input blue, output ready);
endinterface

interface bu2x_res_if;
    import bu2x_pkg::*;

    logic                  valid;
    logic                  ready;
    logic [CH_BITS-1:0]    out_red;
    logic [CH_BITS-1:0]    out_green;
    logic [CH_BITS-1:0]    out_blue;
    logic [COORD_BITS-1:0] out_x;
    logic [COORD_BITS-1:0] out_y;
    logic                  last_of_run;

    modport source (output valid, output out_red, output out_green, output out_blue,
                    output out_x, output out_y, output last_of_run, input ready);
    modport sink (input valid, input out_red, input out_green, input out_blue,
                  input out_x, input out_y, input last_of_run, output ready);
endinterface

### rtl/bu2x_line_buf.sv
// previous-row line buffer with registered read and upper-left pixel register
`timescale 1ns / 1ps

module bu2x_line_buf (
    input  logic                         i_clk,
    input  logic                         i_en,
    input  logic [bu2x_pkg::COL_BITS-1:0] i_addr,
    input  bu2x_pkg::t_pix               i_pix,
    output bu2x_pkg::t_pix               o_up,
    output bu2x_pkg::t_pix               o_ul
);
    import bu2x_pkg::*;

    t_pix r_mem [MAX_WIDTH];
    t_pix r_up;
    t_pix r_ul;

    // read returns the old row value, write stores the new one at the same column
    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_up         <= r_mem[i_addr];
            r_ul         <= r_up;
            r_mem[i_addr] <= i_pix;
        end
    end

    assign o_up = r_up;
    assign o_ul = r_ul;

endmodule

### rtl/bu2x_avg.sv
// per-channel copy, two-pixel and four-pixel truncated averages
`timescale 1ns / 1ps

module bu2x_avg (
    input  bu2x_pkg::t_kind i_kind,
    input  bu2x_pkg::t_pix  i_p,
    input  bu2x_pkg::t_pix  i_l,
    input  bu2x_pkg::t_pix  i_u,
    input  bu2x_pkg::t_pix  i_ul,
    output bu2x_pkg::t_pix  o_pix
);
    import bu2x_pkg::*;

    function automatic logic [CH_BITS-1:0] avg_ch(
        input t_kind              kind,
        input logic [CH_BITS-1:0] p,
        input logic [CH_BITS-1:0] l,
        input logic [CH_BITS-1:0] u,
        input logic [CH_BITS-1:0] ul
    );
        logic [CH_BITS:0]   s_h;
        logic [CH_BITS:0]   s_v;
        logic [CH_BITS+1:0] s_q;
        logic [CH_BITS-1:0] res;
        s_h = {1'b0, l} + {1'b0, p};
        s_v = {1'b0, u} + {1'b0, p};
        s_q = {1'b0, s_h} + {2'b00, u} + {2'b00, ul};
        case (kind)
            K_COPY:  res = p;
            K_HMID:  res = s_h[CH_BITS:1];
            K_VMID:  res = s_v[CH_BITS:1];
            K_QUAD:  res = s_q[CH_BITS+1:2];
            default: res = p;
        endcase
        return res;
    endfunction

    assign o_pix.red   = avg_ch(i_kind, i_p.red,   i_l.red,   i_u.red,   i_ul.red);
    assign o_pix.green = avg_ch(i_kind, i_p.green, i_l.green, i_u.green, i_ul.green);
    assign o_pix.blue  = avg_ch(i_kind, i_p.blue,  i_l.blue,  i_u.blue,  i_ul.blue);

endmodule

### rtl/bilinear_upsample_2x_unit.sv
// top level of the 2x bilinear image upscaler
`timescale 1ns / 1ps

// usage:
//   i_pix takes source RGB pixels in raster order, one transfer per valid/ready pair.
//   o_res gives the upscaled pixels with their coordinates; per source pixel (x,y):
//   copy at (2x,2y), then horizontal mid (x>0), vertical mid (y>0), four-pixel mean
//   (x>0 and y>0); last_of_run marks the final one of that pixel.
//   source_width (0x0) and source_height (0x4) are set over the APB port; the user
//   must do so only while idle, the block does not enforce it. An input transfer loads
//   the working stage, whose first result enters the output register once it is free.
// throughput: one result per cycle while o_res.ready is high; a pixel gives 1 to 4
//   results. The next pixel is taken in the cycle its predecessor gives its last result.
// reset: clears counters and valid flags, sizes go to 640x480; the line buffer is not
//   cleared and is filled by the first row.
// stall: when o_res.ready is low the result register holds, the working pixel waits,
//   and i_pix.ready drops once that pixel still has results to give.
module bilinear_upsample_2x_unit (
    input  logic                           i_clk,
    input  logic                           i_rst_n,
    bu2x_pix_if.sink                       i_pix,
    bu2x_res_if.source                     o_res,
    input  logic                           psel,
    input  logic                           penable,
    input  logic                           pwrite,
    input  logic [bu2x_pkg::ADDR_BITS-1:0] paddr,
    input  logic [bu2x_pkg::APB_DW-1:0]    pwdata,
    output logic [bu2x_pkg::APB_DW-1:0]    prdata,
    output logic                           pready
);
    import bu2x_pkg::*;

    logic [CFG_BITS-1:0]   r_src_w;
    logic [CFG_BITS-1:0]   r_src_h;
    logic [COL_BITS-1:0]   r_col;
    logic [ROW_BITS-1:0]   r_row;
    t_pix                  r_left;

    logic                  r_b_vld;
    t_kind                 r_kind;
    t_pix                  r_p;
    t_pix                  r_l;
    logic [COL_BITS-1:0]   r_x;
    logic [ROW_BITS-1:0]   r_y;

    logic                  r_o_vld;
    t_pix                  r_o_pix;
    logic [COORD_BITS-1:0] r_o_x;
    logic [COORD_BITS-1:0] r_o_y;
    logic                  r_o_last;

    logic                  cfg_wr;
    t_reg                  reg_sel;
    logic [CFG_BITS-1:0]   w_eff;
    logic [CFG_BITS-1:0]   h_eff;
    logic                  col_wrap;
    logic [CFG_BITS-1:0]   row_inc;
    logic [ROW_BITS-1:0]   row_adv;
    logic [COL_BITS-1:0]   cur_x;
    logic [ROW_BITS-1:0]   cur_y;
    logic [CFG_BITS-1:0]   x_inc;
    logic [CFG_BITS-1:0]   y_inc;
    logic [COL_BITS-1:0]   n_col;
    logic [ROW_BITS-1:0]   n_row;

    logic                  load_out;
    logic                  b_fire;
    logic                  has_x;
    logic                  has_y;
    t_kind                 n_kind;
    logic                  kind_last;
    logic                  accept;
    t_pix                  in_pix;
    t_pix                  up_pix;
    t_pix                  ul_pix;
    t_pix                  res_pix;
    logic [COORD_BITS-1:0] res_x;
    logic [COORD_BITS-1:0] res_y;

    // configuration port
    assign pready  = 1'b1;
    assign cfg_wr  = psel && penable && pwrite && pready;
    assign reg_sel = t_reg'(paddr[2]);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_src_w <= WIDTH_RST;
            r_src_h <= HEIGHT_RST;
        end else if (cfg_wr) begin
            case (reg_sel)
                REG_SRC_WIDTH:  r_src_w <= pwdata[CFG_BITS-1:0];
                REG_SRC_HEIGHT: r_src_h <= pwdata[CFG_BITS-1:0];
                default:        r_src_w <= r_src_w;
            endcase
        end
    end

    always_comb begin
        case (reg_sel)
            REG_SRC_WIDTH:  prdata = APB_DW'(r_src_w);
            REG_SRC_HEIGHT: prdata = APB_DW'(r_src_h);
            default:        prdata = '0;
        endcase
    end

    // clamp sizes to 1..max
    assign w_eff = (r_src_w == '0) ? CFG_BITS'(1) : ((r_src_w > WIDTH_MAX) ? WIDTH_MAX : r_src_w);
    assign h_eff = (r_src_h == '0) ? CFG_BITS'(1)
                                   : ((r_src_h > HEIGHT_MAX) ? HEIGHT_MAX : r_src_h);

    // position of the incoming pixel; a column left past a shrunk width wraps first
    assign col_wrap = CFG_BITS'(r_col) >= w_eff;
    assign row_inc  = CFG_BITS'(r_row) + CFG_BITS'(1);
    assign row_adv  = (row_inc >= h_eff) ? '0 : row_inc[ROW_BITS-1:0];
    assign cur_x    = col_wrap ? '0 : r_col;
    assign cur_y    = col_wrap ? row_adv : r_row;
    assign x_inc    = CFG_BITS'(cur_x) + CFG_BITS'(1);
    assign y_inc    = CFG_BITS'(cur_y) + CFG_BITS'(1);

    always_comb begin
        if (x_inc >= w_eff) begin
            n_col = '0;
            n_row = (y_inc >= h_eff) ? '0 : y_inc[ROW_BITS-1:0];
        end else begin
            n_col = x_inc[COL_BITS-1:0];
            n_row = cur_y;
        end
    end

    // result sequencing
    assign load_out = !r_o_vld || o_res.ready;
    assign b_fire   = r_b_vld && load_out;
    assign has_x    = r_x != '0;
    assign has_y    = r_y != '0;

    always_comb begin
        n_kind    = r_kind;
        kind_last = 1'b1;
        case (r_kind)
            K_COPY: begin
                if (has_x) begin
                    n_kind    = K_HMID;
                    kind_last = 1'b0;
                end else if (has_y) begin
                    n_kind    = K_VMID;
                    kind_last = 1'b0;
                end
            end
            K_HMID: begin
                if (has_y) begin
                    n_kind    = K_VMID;
                    kind_last = 1'b0;
                end
            end
            K_VMID: begin
                if (has_x) begin
                    n_kind    = K_QUAD;
                    kind_last = 1'b0;
                end
            end
            K_QUAD: begin
                kind_last = 1'b1;
            end
            default: begin
                kind_last = 1'b1;
            end
        endcase
    end

    assign i_pix.ready  = !r_b_vld || (b_fire && kind_last);
    assign accept       = i_pix.valid && i_pix.ready;
    assign in_pix.red   = i_pix.red;
    assign in_pix.green = i_pix.green;
    assign in_pix.blue  = i_pix.blue;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_b_vld <= 1'b0;
            r_kind  <= K_COPY;
            r_col   <= '0;
            r_row   <= '0;
        end else if (accept) begin
            r_b_vld <= 1'b1;
            r_kind  <= K_COPY;
            r_col   <= n_col;
            r_row   <= n_row;
        end else if (b_fire) begin
            if (kind_last) begin
                r_b_vld <= 1'b0;
            end else begin
                r_kind <= n_kind;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (accept) begin
            r_p    <= in_pix;
            r_l    <= r_left;
            r_left <= in_pix;
            r_x    <= cur_x;
            r_y    <= cur_y;
        end
    end

    bu2x_line_buf u_line_buf (
        .i_clk  (i_clk),
        .i_en   (accept),
        .i_addr (cur_x),
        .i_pix  (in_pix),
        .o_up   (up_pix),
        .o_ul   (ul_pix)
    );

    bu2x_avg u_avg (
        .i_kind (r_kind),
        .i_p    (r_p),
        .i_l    (r_l),
        .i_u    (up_pix),
        .i_ul   (ul_pix),
        .o_pix  (res_pix)
    );

    // odd coordinates belong to the interpolated positions
    assign res_x = COORD_BITS'({r_x, 1'b0})
                 - (((r_kind == K_HMID) || (r_kind == K_QUAD)) ? COORD_BITS'(1) : '0);
    assign res_y = COORD_BITS'({r_y, 1'b0})
                 - (((r_kind == K_VMID) || (r_kind == K_QUAD)) ? COORD_BITS'(1) : '0);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_o_vld <= 1'b0;
        end else if (load_out) begin
            r_o_vld <= r_b_vld;
        end
    end

    always_ff @(posedge i_clk) begin
        if (b_fire) begin
            r_o_pix  <= res_pix;
            r_o_x    <= res_x;
            r_o_y    <= res_y;
            r_o_last <= kind_last;
        end
    end

    assign o_res.valid       = r_o_vld;
    assign o_res.out_red     = r_o_pix.red;
    assign o_res.out_green   = r_o_pix.green;
    assign o_res.out_blue    = r_o_pix.blue;
    assign o_res.out_x       = r_o_x;
    assign o_res.out_y       = r_o_y;
    assign o_res.last_of_run = r_o_last;

    // an accepted pixel is always held for its results
    a_accept_holds: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        accept |=> r_b_vld)
        else $error("accepted pixel not held in the working stage");

    // the first result of every pixel is the copy at even coordinates
    a_copy_even: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (b_fire && (r_kind == K_COPY)) |=> (!r_o_x[0] && !r_o_y[0]))
        else $error("copy result at odd coordinates");

    // a four-pixel mean always closes its run
    a_quad_last: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_o_vld && r_o_x[0] && r_o_y[0]) |-> r_o_last)
        else $error("four-pixel mean not marked last");

    // a copy ends its run only for the top-left source pixel
    a_copy_last_origin: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_o_vld && r_o_last && !r_o_x[0] && !r_o_y[0]) |-> (r_o_x == '0 && r_o_y == '0))
        else $error("copy marked last away from the origin");

endmodule

### tb/sv/tb_top.sv
// self-checking bench for the 2x bilinear upscaler: directed table and random frames
`timescale 1ns / 1ps

module tb_top;
    import bu2x_pkg::*;

    localparam int    N_DIR        = 23;
    localparam int    N_PHASES     = 10;
    localparam int    SETTLE       = 8;
    localparam int    HOLD_CYCLES  = 300;
    localparam int    IDLE_PCT     = 16;
    localparam longint RUN_LIMIT_NS = 5_000_000;

    typedef logic [COORD_BITS-1:0] t_coord;

    // one upscaled pixel as it should leave the block
    typedef struct packed {
        t_pix   pix;
        t_coord x;
        t_coord y;
        logic   last;
    } t_up_pix;

    typedef enum logic {
        STEP_PIX,
        STEP_SIZE
    } t_step_kind;

    typedef struct packed {
        t_step_kind          kind;
        t_reg                sel;
        logic [CFG_BITS-1:0] size;
        t_pix                pix;
        logic                typed;
        t_up_pix             want;
    } t_dir_step;

    logic i_clk = 1'b0;
    logic i_rst_n;

    logic                 psel;
    logic                 penable;
    logic                 pwrite;
    logic [ADDR_BITS-1:0] paddr;
    logic [APB_DW-1:0]    pwdata;
    logic [APB_DW-1:0]    prdata;
    logic                 pready;

    bu2x_pix_if src_if ();
    bu2x_res_if up_if ();

    bilinear_upsample_2x_unit dut (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_pix   (src_if),
        .o_res   (up_if),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready)
    );

    always begin
        #6 i_clk = 1'b1;
        #6 i_clk = 1'b0;
    end

    // upscaler state as the bench sees it
    logic [CFG_BITS-1:0] width_reg;
    logic [CFG_BITS-1:0] height_reg;
    t_pix                line_mem [MAX_WIDTH];
    t_pix                left_px;
    t_pix                ul_px;
    int unsigned         col_cnt;
    int unsigned         row_cnt;
    int unsigned         hi_written;

    t_up_pix upscaled_q [$];

    int  n_pix;
    int  n_res;
    int  n_cfg;
    int  n_fail;
    bit  no_idle;
    bit  stall_out;

    t_dir_step dir_steps [N_DIR];

    function automatic int unsigned eff_size(input logic [CFG_BITS-1:0] v,
                                             input int unsigned lim);
        int unsigned n;
        n = 32'(v);
        if (n == 0) return 1;
        if (n > lim) return lim;
        return n;
    endfunction

    function automatic logic [CH_BITS-1:0] ch_blend(input logic [CH_BITS-1:0] a, b, c, d,
                                                    input bit quad);
        logic [CH_BITS+1:0] s;
        if (quad) begin
            s = {2'b00, a} + {2'b00, b} + {2'b00, c} + {2'b00, d};
            return s[CH_BITS+1:2];
        end
        s = {2'b00, a} + {2'b00, b};
        return s[CH_BITS:1];
    endfunction

    function automatic t_pix blend(input t_pix a, b, c, d, input bit quad);
        t_pix m;
        m.red   = ch_blend(a.red, b.red, c.red, d.red, quad);
        m.green = ch_blend(a.green, b.green, c.green, d.green, quad);
        m.blue  = ch_blend(a.blue, b.blue, c.blue, d.blue, quad);
        return m;
    endfunction

    // works out the upscaled pixels of one accepted source pixel
    function automatic void upscale_pixel(input t_pix p);
        int unsigned w;
        int unsigned h;
        int unsigned x;
        int unsigned y;
        int          n;
        int          i;
        t_pix        up;
        t_up_pix     res [4];
        w = eff_size(width_reg, MAX_WIDTH);
        h = eff_size(height_reg, MAX_HEIGHT);
        // column count left past a shrunken width wraps first
        if (col_cnt >= w) begin
            col_cnt = 0;
            row_cnt++;
            if (row_cnt >= h) row_cnt = 0;
        end
        x  = col_cnt;
        y  = row_cnt;
        up = line_mem[x];
        n  = 0;
        res[n] = '{p, t_coord'(2 * x), t_coord'(2 * y), 1'b0};
        n++;
        if (x > 0) begin
            res[n] = '{blend(left_px, p, '0, '0, 1'b0), t_coord'(2 * x - 1), t_coord'(2 * y), 1'b0};
            n++;
        end
        if (y > 0) begin
            res[n] = '{blend(up, p, '0, '0, 1'b0), t_coord'(2 * x), t_coord'(2 * y - 1), 1'b0};
            n++;
        end
        if (x > 0 && y > 0) begin
            res[n] = '{blend(ul_px, up, left_px, p, 1'b1), t_coord'(2 * x - 1),
                       t_coord'(2 * y - 1), 1'b0};
            n++;
        end
        res[n-1].last = 1'b1;
        for (i = 0; i < n; i++) upscaled_q.push_back(res[i]);

        ul_px       = up;
        line_mem[x] = p;
        left_px     = p;
        if (x + 1 > hi_written) hi_written = x + 1;
        if (x + 1 >= w) begin
            col_cnt = 0;
            row_cnt = y + 1;
            if (row_cnt >= h) row_cnt = 0;
        end else begin
            col_cnt = x + 1;
        end
    endfunction

    // a wider row must not reach line buffer columns that were never filled
    function automatic logic [CFG_BITS-1:0] safe_width(input logic [CFG_BITS-1:0] v);
        if (eff_size(v, MAX_WIDTH) > hi_written && !(col_cnt == 0 && row_cnt == 0))
            return CFG_BITS'(hi_written);
        return v;
    endfunction

    function automatic logic [CH_BITS-1:0] rand_ch();
        case ($urandom_range(7))
            0: return '0;
            1: return '1;
            default: return CH_BITS'($urandom());
        endcase
    endfunction

    function automatic t_pix rand_pix();
        t_pix p;
        p.red   = rand_ch();
        p.green = rand_ch();
        p.blue  = rand_ch();
        return p;
    endfunction

    function automatic logic [CFG_BITS-1:0] rand_size(input int unsigned common_hi);
        int unsigned k;
        k = $urandom_range(19);
        if (k == 0) return '0;
        if (k == 1) return CFG_BITS'(1);
        if (k == 2) return CFG_BITS'($urandom_range(2047, 1025));
        if (k <= 4) return CFG_BITS'($urandom_range(64, 13));
        return CFG_BITS'($urandom_range(common_hi, 2));
    endfunction

    function automatic t_pix rgb(input logic [CH_BITS-1:0] r, g, b);
        t_pix p;
        p.red   = r;
        p.green = g;
        p.blue  = b;
        return p;
    endfunction

    function automatic t_dir_step size_step(input t_reg r, input logic [CFG_BITS-1:0] v);
        t_dir_step s;
        s      = '0;
        s.kind = STEP_SIZE;
        s.sel  = r;
        s.size = v;
        return s;
    endfunction

    function automatic t_dir_step pix_step(input logic [CH_BITS-1:0] r, g, b);
        t_dir_step s;
        s      = '0;
        s.kind = STEP_PIX;
        s.pix  = rgb(r, g, b);
        return s;
    endfunction

    // pixel whose final upscaled result is written out by hand
    function automatic t_dir_step typed_step(input logic [CH_BITS-1:0] r, g, b, er, eg, eb,
                                             input int unsigned x, y);
        t_dir_step s;
        s       = pix_step(r, g, b);
        s.typed = 1'b1;
        s.want  = '{rgb(er, eg, eb), t_coord'(x), t_coord'(y), 1'b1};
        return s;
    endfunction

    function automatic void field_check(input string name, input logic [31:0] want, got);
        if (got !== want) begin
            $error("%s: expected %0h, got %0h", name, want, got);
            n_fail++;
        end
    endfunction

    task automatic offer_pixel(input t_pix p);
        while (!no_idle && $urandom_range(99) < IDLE_PCT) begin
            src_if.valid <= 1'b0;
            @(posedge i_clk);
        end
        src_if.valid <= 1'b1;
        src_if.red   <= p.red;
        src_if.green <= p.green;
        src_if.blue  <= p.blue;
        @(posedge i_clk);
        while (!src_if.ready) @(posedge i_clk);
        upscale_pixel(p);
        n_pix++;
    endtask

    // stop offering and let every pending upscaled pixel come out
    task automatic drain();
        src_if.valid <= 1'b0;
        @(posedge i_clk);
        while (upscaled_q.size() != 0) @(posedge i_clk);
        repeat (SETTLE) @(posedge i_clk);
    endtask

    task automatic apb_write(input t_reg r, input logic [APB_DW-1:0] d);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= {r, 2'b00};
        pwdata  <= d;
        @(posedge i_clk);
        penable <= 1'b1;
        @(posedge i_clk);
        while (!pready) @(posedge i_clk);
        psel    <= 1'b0;
        penable <= 1'b0;
        @(posedge i_clk);
    endtask

    task automatic apb_read_check(input t_reg r, input logic [APB_DW-1:0] want);
        logic [APB_DW-1:0] got;
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b0;
        paddr   <= {r, 2'b00};
        @(posedge i_clk);
        penable <= 1'b1;
        @(posedge i_clk);
        while (!pready) @(posedge i_clk);
        got = prdata;
        psel    <= 1'b0;
        penable <= 1'b0;
        @(posedge i_clk);
        field_check(r == REG_SRC_WIDTH ? "source_width" : "source_height", want, got);
    endtask

    // upper data bits are junk, only the low register bits count
    task automatic set_size(input t_reg r, input logic [CFG_BITS-1:0] v);
        logic [APB_DW-1:0] d;
        d               = $urandom();
        d[CFG_BITS-1:0] = v;
        apb_write(r, d);
        if (r == REG_SRC_WIDTH) width_reg = v;
        else height_reg = v;
        apb_read_check(r, APB_DW'(v));
        n_cfg++;
    endtask

    // finish the current frame quickly by shrinking it to one row
    task automatic rewind_frame();
        drain();
        set_size(REG_SRC_HEIGHT, CFG_BITS'(1));
        while (col_cnt != 0 || row_cnt != 0) offer_pixel(rand_pix());
    endtask

    // result side: checks every transfer and stalls at random
    initial begin
        int      hold_left;
        bit      held;
        t_up_pix want;
        hold_left = 0;
        held      = 1'b0;
        up_if.ready <= 1'b0;
        forever begin
            @(posedge i_clk);
            if (up_if.valid && up_if.ready) begin
                if (upscaled_q.size() == 0) begin
                    $error("upscaled pixel at (%0d,%0d) with nothing expected",
                           up_if.out_x, up_if.out_y);
                    n_fail++;
                end else begin
                    want = upscaled_q.pop_front();
                    n_res++;
                    field_check("out_red", 32'(want.pix.red), 32'(up_if.out_red));
                    field_check("out_green", 32'(want.pix.green), 32'(up_if.out_green));
                    field_check("out_blue", 32'(want.pix.blue), 32'(up_if.out_blue));
                    field_check("out_x", 32'(want.x), 32'(up_if.out_x));
                    field_check("out_y", 32'(want.y), 32'(up_if.out_y));
                    field_check("last_of_run", 32'(want.last), 32'(up_if.last_of_run));
                end
            end
            if (stall_out && !held) begin
                held      = 1'b1;
                hold_left = HOLD_CYCLES;
            end
            if (hold_left > 0) begin
                hold_left--;
                up_if.ready <= 1'b0;
            end else begin
                up_if.ready <= no_idle || ($urandom_range(99) >= IDLE_PCT);
            end
        end
    end

    initial begin
        #(RUN_LIMIT_NS);
        $display("Test completed with failures");
        $finish;
    end

    initial begin
        int ph;
        int k;
        int cnt;
        int pick;

        width_reg  = WIDTH_RST;
        height_reg = HEIGHT_RST;
        left_px    = '0;
        ul_px      = '0;
        col_cnt    = 0;
        row_cnt    = 0;
        hi_written = 0;
        n_pix      = 0;
        n_res      = 0;
        n_cfg      = 0;
        n_fail     = 0;
        no_idle    = 1'b0;
        stall_out  = 1'b0;

        i_rst_n      <= 1'b0;
        src_if.valid <= 1'b0;
        src_if.red   <= '0;
        src_if.green <= '0;
        src_if.blue  <= '0;
        psel         <= 1'b0;
        penable      <= 1'b0;
        pwrite       <= 1'b0;
        paddr        <= '0;
        pwdata       <= '0;

        dir_steps = '{
            size_step(REG_SRC_WIDTH, CFG_BITS'(2)),
            size_step(REG_SRC_HEIGHT, CFG_BITS'(2)),
            // 2x2 frame: copy, horizontal mid, vertical mid, four-pixel mean
            typed_step(16'hFFFF, 16'h0000, 16'h1234, 16'hFFFF, 16'h0000, 16'h1234, 0, 0),
            typed_step(16'h0001, 16'hFFFF, 16'h8000, 16'h8000, 16'h7FFF, 16'h491A, 1, 0),
            typed_step(16'hFFFF, 16'hFFFF, 16'hFFFF, 16'hFFFF, 16'h7FFF, 16'h8919, 0, 1),
            typed_step(16'h0000, 16'h0000, 16'h0000, 16'h7FFF, 16'h7FFF, 16'h648C, 1, 1),
            // zero sizes act as a 1x1 image
            size_step(REG_SRC_WIDTH, CFG_BITS'(0)),
            size_step(REG_SRC_HEIGHT, CFG_BITS'(0)),
            typed_step(16'h0001, 16'h0002, 16'h0003, 16'h0001, 16'h0002, 16'h0003, 0, 0),
            typed_step(16'hFFFF, 16'hFFFF, 16'hFFFF, 16'hFFFF, 16'hFFFF, 16'hFFFF, 0, 0),
            // oversize values clamp to the maximum
            size_step(REG_SRC_WIDTH, '1),
            size_step(REG_SRC_HEIGHT, '1),
            pix_step(16'h1111, 16'h2222, 16'h3333),
            pix_step(16'hA5A5, 16'h5A5A, 16'hFFFF),
            pix_step(16'h0000, 16'h8000, 16'h7FFF),
            // width shrinks to the current column count mid-row
            size_step(REG_SRC_WIDTH, CFG_BITS'(3)),
            pix_step(16'h0102, 16'h0304, 16'h0506),
            pix_step(16'hFFFE, 16'h0001, 16'hFFFF),
            pix_step(16'h1357, 16'h9BDF, 16'h2468),
            // height shrinks below the row count, wraps at the end of the row
            size_step(REG_SRC_HEIGHT, CFG_BITS'(1)),
            pix_step(16'h8001, 16'h7FFE, 16'h0F0F),
            pix_step(16'hF0F0, 16'h0FF0, 16'hFF00),
            pix_step(16'h0000, 16'hFFFF, 16'h0000)
        };

        repeat (4) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        apb_read_check(REG_SRC_WIDTH, APB_DW'(WIDTH_RST));
        apb_read_check(REG_SRC_HEIGHT, APB_DW'(HEIGHT_RST));

        foreach (dir_steps[i]) begin
            if (dir_steps[i].kind == STEP_SIZE) begin
                drain();
                set_size(dir_steps[i].sel, dir_steps[i].size);
            end else begin
                offer_pixel(dir_steps[i].pix);
                if (dir_steps[i].typed) upscaled_q[upscaled_q.size()-1] = dir_steps[i].want;
            end
        end

        // back to the top of a frame before the random part
        rewind_frame();

        // random frames with size changes wherever the counters happen to be
        for (ph = 0; ph < N_PHASES; ph++) begin
            drain();
            pick = $urandom_range(3);
            if (pick != 1) set_size(REG_SRC_WIDTH, safe_width(rand_size(12)));
            if (pick != 0) set_size(REG_SRC_HEIGHT, rand_size(6));
            no_idle = (ph == 2);
            if (ph == 4) stall_out = 1'b1;
            cnt = $urandom_range(45, 20);
            for (k = 0; k < cnt; k++) begin
                if (ph == 6 && k == cnt / 2) drain();
                offer_pixel(rand_pix());
            end
            no_idle = 1'b0;
        end

        drain();
        $display("covered %0d source pixels, %0d upscaled pixels checked, %0d size writes",
                 n_pix, n_res, n_cfg);
        $display("incl. edge values, size clamps, mid-frame resizes, output stall");
        if (n_fail == 0) begin
            $display("Test completed successfully");
        end else begin
            $display("Test completed with failures");
        end
        $finish;
    end

endmodule

### filelist.f
rtl/bu2x_pkg.sv
rtl/bu2x_if.sv
rtl/bu2x_line_buf.sv
rtl/bu2x_avg.sv
rtl/bilinear_upsample_2x_unit.sv
tb/sv/tb_top.sv
